// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of this block (j2m_checker).
// No dependencies; every macro clocks on a rising edge and stops during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("port check failed");

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_AT(label, clk, rst_n, !(cond))

`endif

// ===== hw/rtl/j2m_pkg.sv =====
// Shared widths, types and constants of the Jones-to-Mueller converter.
// No dependencies; used by j2m_datapath, the top level and the checker.
`timescale 1ns / 1ps

package j2m_pkg;

  localparam int unsigned InW   = 18;           // Jones part, 15 fractional bits
  localparam int unsigned ProdW = 2 * InW;      // one real product
  localparam int unsigned SumW  = ProdW + 1;    // sum of two products
  localparam int unsigned OutW  = 40;           // Mueller element, 30 fractional bits
  localparam int unsigned Rows  = 4;
  localparam int unsigned RowW  = $clog2(Rows);

  typedef logic signed [InW-1:0]  in_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [OutW-1:0]  elem_t;
  typedef logic [RowW-1:0]         row_t;

  localparam row_t FirstRow = row_t'(0);
  localparam row_t LastRow  = row_t'(Rows - 1);

  // One complex Jones matrix.
  typedef struct packed {
    in_t j00_re;
    in_t j00_im;
    in_t j01_re;
    in_t j01_im;
    in_t j10_re;
    in_t j10_im;
    in_t j11_re;
    in_t j11_im;
  } jones_t;

  // Mueller matrix indexed [row][column].
  typedef elem_t [Rows-1:0][Rows-1:0] mat_t;

  // Control handed to the datapath and status handed back.
  typedef struct packed {
    logic advance;
    logic in_valid;
  } pipe_ctl_t;

  typedef struct packed {
    logic out_valid;
  } pipe_stat_t;

endpackage

// ===== hw/rtl/j2m_datapath.sv =====
// Three-stage arithmetic pipeline: products, pair sums, Mueller elements.
// Depends on j2m_pkg for widths, the Jones and matrix types and control structs.
`timescale 1ns / 1ps

module j2m_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  j2m_pkg::pipe_ctl_t ctl_i,
  input  j2m_pkg::jones_t    jones_i,
  output j2m_pkg::pipe_stat_t stat_o,
  output j2m_pkg::mat_t      mat_o
);

  localparam int unsigned NPair = 6;  // C1, C2, D1, D2, E1, E2
  localparam int unsigned NMag  = 4;  // |J00|^2, |J01|^2, |J10|^2, |J11|^2

  typedef struct packed {
    j2m_pkg::prod_t rr;
    j2m_pkg::prod_t ii;
    j2m_pkg::prod_t ir;
    j2m_pkg::prod_t ri;
  } cprod_t;

  typedef struct packed {
    j2m_pkg::prod_t re2;
    j2m_pkg::prod_t im2;
  } sq_t;

  // Operands of a * conj(b) for each pair, and of each squared magnitude.
  j2m_pkg::in_t a_re [NPair];
  j2m_pkg::in_t a_im [NPair];
  j2m_pkg::in_t b_re [NPair];
  j2m_pkg::in_t b_im [NPair];
  j2m_pkg::in_t m_re [NMag];
  j2m_pkg::in_t m_im [NMag];

  logic [2:0] v_q;

  cprod_t cp_d [NPair];
  cprod_t cp_q [NPair];
  sq_t    sq_d [NMag];
  sq_t    sq_q [NMag];

  j2m_pkg::sum_t cre_d [NPair];
  j2m_pkg::sum_t cim_d [NPair];
  j2m_pkg::sum_t cre_q [NPair];
  j2m_pkg::sum_t cim_q [NPair];
  j2m_pkg::sum_t mag_d [NMag];
  j2m_pkg::sum_t mag_q [NMag];

  j2m_pkg::mat_t mat_d;
  j2m_pkg::mat_t mat_q;

  always_comb begin
    a_re[0] = jones_i.j00_re; a_im[0] = jones_i.j00_im;  // C1 = J00*conj(J01)
    b_re[0] = jones_i.j01_re; b_im[0] = jones_i.j01_im;
    a_re[1] = jones_i.j11_re; a_im[1] = jones_i.j11_im;  // C2 = J11*conj(J10)
    b_re[1] = jones_i.j10_re; b_im[1] = jones_i.j10_im;
    a_re[2] = jones_i.j00_re; a_im[2] = jones_i.j00_im;  // D1 = J00*conj(J10)
    b_re[2] = jones_i.j10_re; b_im[2] = jones_i.j10_im;
    a_re[3] = jones_i.j11_re; a_im[3] = jones_i.j11_im;  // D2 = J11*conj(J01)
    b_re[3] = jones_i.j01_re; b_im[3] = jones_i.j01_im;
    a_re[4] = jones_i.j00_re; a_im[4] = jones_i.j00_im;  // E1 = J00*conj(J11)
    b_re[4] = jones_i.j11_re; b_im[4] = jones_i.j11_im;
    a_re[5] = jones_i.j01_re; a_im[5] = jones_i.j01_im;  // E2 = J01*conj(J10)
    b_re[5] = jones_i.j10_re; b_im[5] = jones_i.j10_im;
    m_re[0] = jones_i.j00_re; m_im[0] = jones_i.j00_im;
    m_re[1] = jones_i.j01_re; m_im[1] = jones_i.j01_im;
    m_re[2] = jones_i.j10_re; m_im[2] = jones_i.j10_im;
    m_re[3] = jones_i.j11_re; m_im[3] = jones_i.j11_im;
  end

  // Stage 1: every real product, one 18x18 multiplier each.
  always_comb begin
    for (int k = 0; k < NPair; k++) begin
      cp_d[k].rr = j2m_pkg::prod_t'(a_re[k]) * j2m_pkg::prod_t'(b_re[k]);
      cp_d[k].ii = j2m_pkg::prod_t'(a_im[k]) * j2m_pkg::prod_t'(b_im[k]);
      cp_d[k].ir = j2m_pkg::prod_t'(a_im[k]) * j2m_pkg::prod_t'(b_re[k]);
      cp_d[k].ri = j2m_pkg::prod_t'(a_re[k]) * j2m_pkg::prod_t'(b_im[k]);
    end
    for (int k = 0; k < NMag; k++) begin
      sq_d[k].re2 = j2m_pkg::prod_t'(m_re[k]) * j2m_pkg::prod_t'(m_re[k]);
      sq_d[k].im2 = j2m_pkg::prod_t'(m_im[k]) * j2m_pkg::prod_t'(m_im[k]);
    end
  end

  // Stage 2: complex parts and squared magnitudes.
  always_comb begin
    for (int k = 0; k < NPair; k++) begin
      cre_d[k] = j2m_pkg::sum_t'(cp_q[k].rr) + j2m_pkg::sum_t'(cp_q[k].ii);
      cim_d[k] = j2m_pkg::sum_t'(cp_q[k].ir) - j2m_pkg::sum_t'(cp_q[k].ri);
    end
    for (int k = 0; k < NMag; k++) begin
      mag_d[k] = j2m_pkg::sum_t'(sq_q[k].re2) + j2m_pkg::sum_t'(sq_q[k].im2);
    end
  end

  // Stage 3: signed combinations; the halved terms round toward minus infinity.
  always_comb begin
    j2m_pkg::elem_t a11, a12, a21, a22;
    j2m_pkg::elem_t c1r, c1i, c2r, c2i, d1r, d1i, d2r, d2i, e1r, e1i, e2r, e2i;
    j2m_pkg::elem_t h00, h01, h10, h11;
    a11 = j2m_pkg::elem_t'(mag_q[0]);
    a12 = j2m_pkg::elem_t'(mag_q[1]);
    a21 = j2m_pkg::elem_t'(mag_q[2]);
    a22 = j2m_pkg::elem_t'(mag_q[3]);
    c1r = j2m_pkg::elem_t'(cre_q[0]); c1i = j2m_pkg::elem_t'(cim_q[0]);
    c2r = j2m_pkg::elem_t'(cre_q[1]); c2i = j2m_pkg::elem_t'(cim_q[1]);
    d1r = j2m_pkg::elem_t'(cre_q[2]); d1i = j2m_pkg::elem_t'(cim_q[2]);
    d2r = j2m_pkg::elem_t'(cre_q[3]); d2i = j2m_pkg::elem_t'(cim_q[3]);
    e1r = j2m_pkg::elem_t'(cre_q[4]); e1i = j2m_pkg::elem_t'(cim_q[4]);
    e2r = j2m_pkg::elem_t'(cre_q[5]); e2i = j2m_pkg::elem_t'(cim_q[5]);
    h00 = a11 + a21 + a12 + a22;
    h01 = a11 + a21 - a12 - a22;
    h10 = a11 - a21 + a12 - a22;
    h11 = a11 - a21 - a12 + a22;

    mat_d[0][0] = h00 >>> 1;
    mat_d[0][1] = h01 >>> 1;
    mat_d[0][2] = -c1r - c2r;
    mat_d[0][3] = c2i - c1i;
    mat_d[1][0] = h10 >>> 1;
    mat_d[1][1] = h11 >>> 1;
    mat_d[1][2] = c2r - c1r;
    mat_d[1][3] = -c1i - c2i;
    mat_d[2][0] = -d1r - d2r;
    mat_d[2][1] = d2r - d1r;
    mat_d[2][2] = e1r + e2r;
    mat_d[2][3] = e1i - e2i;
    mat_d[3][0] = d1i - d2i;
    mat_d[3][1] = d2i + d1i;
    mat_d[3][2] = -e1i - e2i;
    mat_d[3][3] = e1r - e2r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (ctl_i.advance) begin
      v_q <= {v_q[1:0], ctl_i.in_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      cp_q  <= cp_d;
      sq_q  <= sq_d;
      cre_q <= cre_d;
      cim_q <= cim_d;
      mag_q <= mag_d;
      mat_q <= mat_d;
    end
  end

  assign stat_o.out_valid = v_q[2];
  assign mat_o            = mat_q;

endmodule

// ===== hw/rtl/jones_to_mueller_conversion.sv =====
// Top level of the Jones-to-Mueller converter: input handshake, arithmetic
// pipeline (j2m_datapath) and the row serializer. Depends on j2m_pkg.
//
//   Channel | Handshake              | Carries
//   --------+------------------------+-------------------------------------------
//   in      | in_valid_i / in_ready_o | one Jones matrix, eight 18-bit parts
//   out     | out_valid_o/out_ready_i | one Mueller row: index, four 40-bit columns
//
// A matrix passes the product, pair-sum and element registers of the pipeline
// and then the serializer register, from which its rows are driven out.
// Rows leave one per cycle while out_ready_i is high, and the single-row
// output port sets the matrix rate while later matrices wait in the pipeline.
// Reset clears only the valid bits and the row counter; data registers keep
// whatever they hold. A busy serializer freezes the pipeline only once its
// final stage holds a matrix; bubbles ahead of that stage keep moving.
`timescale 1ns / 1ps

module jones_to_mueller_conversion (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  j2m_pkg::in_t         j00_re_i,
  input  j2m_pkg::in_t         j00_im_i,
  input  j2m_pkg::in_t         j01_re_i,
  input  j2m_pkg::in_t         j01_im_i,
  input  j2m_pkg::in_t         j10_re_i,
  input  j2m_pkg::in_t         j10_im_i,
  input  j2m_pkg::in_t         j11_re_i,
  input  j2m_pkg::in_t         j11_im_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output j2m_pkg::row_t        row_index_o,
  output j2m_pkg::elem_t       col0_o,
  output j2m_pkg::elem_t       col1_o,
  output j2m_pkg::elem_t       col2_o,
  output j2m_pkg::elem_t       col3_o,
  output logic                 last_row_o
);

  j2m_pkg::jones_t     jones;
  j2m_pkg::pipe_ctl_t  ctl;
  j2m_pkg::pipe_stat_t stat;
  j2m_pkg::mat_t       dp_mat;

  // The serializer holds one full matrix and walks through its rows.
  j2m_pkg::mat_t mat_q;
  j2m_pkg::row_t row_q;
  logic          sv_q;
  logic          ser_free;

  assign jones.j00_re = j00_re_i;
  assign jones.j00_im = j00_im_i;
  assign jones.j01_re = j01_re_i;
  assign jones.j01_im = j01_im_i;
  assign jones.j10_re = j10_re_i;
  assign jones.j10_im = j10_im_i;
  assign jones.j11_re = j11_re_i;
  assign jones.j11_im = j11_im_i;

  // The serializer can take a new matrix when it is empty or when its last
  // row is leaving in this cycle.
  assign ser_free = !sv_q || (out_ready_i && (row_q == j2m_pkg::LastRow));

  // The pipeline moves whenever its final stage is empty or can be handed on,
  // so bubbles in flight never block a new request.
  assign ctl.advance  = !stat.out_valid || ser_free;
  assign ctl.in_valid = in_valid_i;
  assign in_ready_o   = ctl.advance;

  j2m_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .jones_i(jones),
    .stat_o (stat),
    .mat_o  (dp_mat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q  <= 1'b0;
      row_q <= j2m_pkg::FirstRow;
    end else if (ser_free) begin
      sv_q  <= stat.out_valid;
      row_q <= j2m_pkg::FirstRow;
    end else if (out_ready_i) begin
      row_q <= j2m_pkg::row_t'(row_q + 1'b1);
    end
  end

  // Matrix payload needs no reset; it is loaded together with sv_q.
  always_ff @(posedge clk_i) begin
    if (ser_free && stat.out_valid) begin
      mat_q <= dp_mat;
    end
  end

  assign out_valid_o = sv_q;
  assign row_index_o = row_q;
  assign col0_o      = mat_q[row_q][0];
  assign col1_o      = mat_q[row_q][1];
  assign col2_o      = mat_q[row_q][2];
  assign col3_o      = mat_q[row_q][3];
  assign last_row_o  = (row_q == j2m_pkg::LastRow);

endmodule

// ===== hw/rtl/j2m_checker.sv =====
// Port-level checker for the Jones-to-Mueller converter, bound to the top level.
// Depends on j2m_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module j2m_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input j2m_pkg::in_t   j00_re_i,
  input j2m_pkg::in_t   j00_im_i,
  input j2m_pkg::in_t   j01_re_i,
  input j2m_pkg::in_t   j01_im_i,
  input j2m_pkg::in_t   j10_re_i,
  input j2m_pkg::in_t   j10_im_i,
  input j2m_pkg::in_t   j11_re_i,
  input j2m_pkg::in_t   j11_im_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input j2m_pkg::row_t  row_index_o,
  input j2m_pkg::elem_t col0_o,
  input j2m_pkg::elem_t col1_o,
  input j2m_pkg::elem_t col2_o,
  input j2m_pkg::elem_t col3_o,
  input logic           last_row_o
);

  // A waiting request keeps its valid and all eight matrix parts.
  `ASSERT_AT(a_in_hold, clk_i, rst_ni,
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(j00_re_i) && $stable(j00_im_i)
    && $stable(j01_re_i) && $stable(j01_im_i) && $stable(j10_re_i) && $stable(j10_im_i)
    && $stable(j11_re_i) && $stable(j11_im_i))

  // A stalled result keeps its row and every column.
  `ASSERT_AT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o) && $stable(col0_o)
    && $stable(col1_o) && $stable(col2_o) && $stable(col3_o) && $stable(last_row_o))

  // The last-row flag marks exactly the final row.
  `ASSERT_NEVER(a_last_flag, clk_i, rst_ni, out_valid_o && (last_row_o != (row_index_o == j2m_pkg::LastRow)))

  // Rows of one matrix follow one another without a gap.
  `ASSERT_AT(a_row_step, clk_i, rst_ni, out_valid_o && out_ready_i && !last_row_o |=> out_valid_o && (row_index_o == j2m_pkg::row_t'($past(row_index_o) + 1'b1)))

  // A new matrix starts at the first row.
  `ASSERT_AT(a_row_start, clk_i, rst_ni, out_valid_o && out_ready_i && last_row_o |=> !out_valid_o || (row_index_o == j2m_pkg::FirstRow))

endmodule

bind jones_to_mueller_conversion j2m_checker u_j2m_checker (.*);
